>>> rtl/srt_pkg.sv
// types, codes and box helper for the selection rectangle tracker
package srt_pkg;

    // event codes
    localparam logic [2:0] OP_SELECT_PRESS   = 3'd0;
    localparam logic [2:0] OP_MENU_PRESS     = 3'd1;
    localparam logic [2:0] OP_SELECT_RELEASE = 3'd2;
    localparam logic [2:0] OP_MOVE           = 3'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_CLIP_LEFT   = 2'd0;
    localparam logic [1:0] CFG_CLIP_TOP    = 2'd1;
    localparam logic [1:0] CFG_CLIP_RIGHT  = 2'd2;
    localparam logic [1:0] CFG_CLIP_BOTTOM = 2'd3;

    localparam int CLIP_W = 15;
    localparam int COORD_W = 16;

    localparam logic [CLIP_W-1:0] CLIP_LEFT_RESET   = 15'd0;
    localparam logic [CLIP_W-1:0] CLIP_TOP_RESET    = 15'd0;
    localparam logic [CLIP_W-1:0] CLIP_RIGHT_RESET  = 15'd639;
    localparam logic [CLIP_W-1:0] CLIP_BOTTOM_RESET = 15'd199;
    localparam logic [COORD_W-1:0] PATTERN_RESET    = 16'hF0F0;

    typedef struct packed {
        logic [2:0]         opcode;
        logic signed [15:0] pointer_x;
        logic signed [15:0] pointer_y;
        logic signed [15:0] shift_x;
        logic signed [15:0] shift_y;
    } srt_in_t;

    typedef struct packed {
        logic [15:0] box_left;
        logic [15:0] box_top;
        logic [15:0] box_width;
        logic [15:0] box_height;
        logic [15:0] anchor_x;
        logic [15:0] anchor_y;
        logic [15:0] far_x;
        logic [15:0] far_y;
        logic [15:0] dash_pattern;
        logic        dragging;
        logic        was_inside;
    } srt_out_t;

    typedef struct packed {
        logic [15:0] left;
        logic [15:0] top;
        logic [15:0] width;
        logic [15:0] height;
    } srt_box_t;

    // normalized box from two corners, sizes wrap modulo 2^16
    function automatic srt_box_t srt_rebuild(input logic [15:0] ax, input logic [15:0] ay,
                                             input logic [15:0] fx, input logic [15:0] fy);
        srt_box_t    b;
        logic [15:0] lx;
        logic [15:0] hx;
        logic [15:0] ly;
        logic [15:0] hy;
        lx = (ax < fx) ? ax : fx;
        hx = (ax < fx) ? fx : ax;
        ly = (ay < fy) ? ay : fy;
        hy = (ay < fy) ? fy : ay;
        b.left   = lx;
        b.top    = ly;
        b.width  = hx - lx + 16'd1;
        b.height = hy - ly + 16'd1;
        return b;
    endfunction

endpackage

>>> rtl/selection_rectangle_tracker.sv
// selection rectangle tracker top level: pointer event in, box state word out
//
// usage
//   input channel: one pointer event word per accepted transfer (in_valid high,
//   in_stall low at a rising edge). fields: opcode, pointer x/y, anchor shift x/y
//   output channel: one result word per event, in event order (out_valid high,
//   out_stall low). the word holds the normalized box, both corners, the dash
//   pattern, the drag flag and whether the pointer needed no clamping
//   config port: cfg_write with cfg_index/cfg_data sets the clip window; write
//   only while no event is in flight
//   latency: an event shows on the output one cycle after the edge that accepts
//   it (input register at that edge, result register at the next one)
//   throughput: one event per cycle, set by the single-cycle state update
//   between the two registers
//   reset: clip window back to 0..639 x 0..199, corners and box zero, dash
//   pattern 0xF0F0, no drag, both pipeline registers empty
//   stall: a stalled result holds in the output register; the input register
//   still takes one more event and then in_stall rises until the result drains
module selection_rectangle_tracker
    import srt_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  srt_in_t             in_word,
    output logic                out_valid,
    input  logic                out_stall,
    output srt_out_t            out_word,
    input  logic                cfg_write,
    input  logic [1:0]          cfg_index,
    input  logic [CLIP_W-1:0]   cfg_data
);

    // clip window
    logic [CLIP_W-1:0] clip_left_reg;
    logic [CLIP_W-1:0] clip_top_reg;
    logic [CLIP_W-1:0] clip_right_reg;
    logic [CLIP_W-1:0] clip_bottom_reg;

    // pipeline registers
    logic     in_valid_reg;
    srt_in_t  in_word_reg;
    logic     out_valid_reg;
    srt_out_t out_word_reg;
    srt_out_t out_word_next;

    // tracker state
    logic [15:0] anchor_x_reg, anchor_x_next;
    logic [15:0] anchor_y_reg, anchor_y_next;
    logic [15:0] far_x_reg, far_x_next;
    logic [15:0] far_y_reg, far_y_next;
    srt_box_t    box_reg, box_next;
    logic [15:0] pattern_reg, pattern_next;
    logic        drag_active_reg, drag_active_next;
    logic        bounding_mode_reg, bounding_mode_next;

    // the event in the input register is processed when the result slot is free
    logic advance;
    assign advance  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !advance;

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clip_left_reg   <= CLIP_LEFT_RESET;
            clip_top_reg    <= CLIP_TOP_RESET;
            clip_right_reg  <= CLIP_RIGHT_RESET;
            clip_bottom_reg <= CLIP_BOTTOM_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_CLIP_LEFT:   clip_left_reg   <= cfg_data;
                CFG_CLIP_TOP:    clip_top_reg    <= cfg_data;
                CFG_CLIP_RIGHT:  clip_right_reg  <= cfg_data;
                CFG_CLIP_BOTTOM: clip_bottom_reg <= cfg_data;
            endcase
        end
    end

    // clamp, then the per-event state update
    logic signed [16:0] px_ext, py_ext;
    logic signed [16:0] lo_x, hi_x, lo_y, hi_y;
    logic               in_window;
    logic [15:0]        mx, my;
    logic               rotate_right;

    always_comb
    begin
        px_ext    = {in_word_reg.pointer_x[15], in_word_reg.pointer_x};
        py_ext    = {in_word_reg.pointer_y[15], in_word_reg.pointer_y};
        lo_x      = {2'b00, clip_left_reg};
        hi_x      = {2'b00, clip_right_reg};
        lo_y      = {2'b00, clip_top_reg};
        hi_y      = {2'b00, clip_bottom_reg};
        in_window = 1'b1;

        // low bound first: an empty window clamps values under it low, rest high
        if (px_ext < lo_x)
        begin
            mx        = {1'b0, clip_left_reg};
            in_window = 1'b0;
        end
        else if (px_ext > hi_x)
        begin
            mx        = {1'b0, clip_right_reg};
            in_window = 1'b0;
        end
        else
        begin
            mx = in_word_reg.pointer_x;
        end

        if (py_ext < lo_y)
        begin
            my        = {1'b0, clip_top_reg};
            in_window = 1'b0;
        end
        else if (py_ext > hi_y)
        begin
            my        = {1'b0, clip_bottom_reg};
            in_window = 1'b0;
        end
        else
        begin
            my = in_word_reg.pointer_y;
        end

        rotate_right = (anchor_x_reg < far_x_reg) || (anchor_y_reg > far_y_reg);

        anchor_x_next      = anchor_x_reg;
        anchor_y_next      = anchor_y_reg;
        far_x_next         = far_x_reg;
        far_y_next         = far_y_reg;
        box_next           = box_reg;
        pattern_next       = pattern_reg;
        drag_active_next   = drag_active_reg;
        bounding_mode_next = bounding_mode_reg;

        unique case (in_word_reg.opcode)
            OP_SELECT_PRESS:
            begin
                drag_active_next   = 1'b0;
                bounding_mode_next = 1'b0;
                if (in_window)
                begin
                    anchor_x_next      = mx;
                    anchor_y_next      = my;
                    far_x_next         = mx;
                    far_y_next         = my;
                    box_next           = srt_rebuild(mx, my, mx, my);
                    drag_active_next   = 1'b1;
                    bounding_mode_next = 1'b1;
                end
            end
            OP_MENU_PRESS:
            begin
                drag_active_next   = 1'b0;
                bounding_mode_next = 1'b0;
                box_next.width     = '0;
                box_next.height    = '0;
            end
            OP_SELECT_RELEASE:
            begin
                if (bounding_mode_reg)
                begin
                    box_next = srt_rebuild(anchor_x_reg, anchor_y_reg, far_x_reg, far_y_reg);
                end
                drag_active_next   = 1'b0;
                bounding_mode_next = 1'b0;
            end
            OP_MOVE:
            begin
                if (drag_active_reg)
                begin
                    if (rotate_right)
                    begin
                        pattern_next = {pattern_reg[0], pattern_reg[15:1]};
                    end
                    else
                    begin
                        pattern_next = {pattern_reg[14:0], pattern_reg[15]};
                    end
                    // anchor shifts only when both adjustments are nonzero
                    if ((in_word_reg.shift_x != '0) && (in_word_reg.shift_y != '0))
                    begin
                        anchor_x_next = anchor_x_reg + in_word_reg.shift_x;
                        anchor_y_next = anchor_y_reg + in_word_reg.shift_y;
                    end
                    else
                    begin
                        far_x_next = mx;
                        far_y_next = my;
                    end
                    if (bounding_mode_reg)
                    begin
                        box_next = srt_rebuild(anchor_x_next, anchor_y_next,
                                               far_x_next, far_y_next);
                    end
                end
            end
            default:
            begin
                // other button and unused codes leave the state alone
            end
        endcase

        out_word_next.box_left     = box_next.left;
        out_word_next.box_top      = box_next.top;
        out_word_next.box_width    = box_next.width;
        out_word_next.box_height   = box_next.height;
        out_word_next.anchor_x     = anchor_x_next;
        out_word_next.anchor_y     = anchor_y_next;
        out_word_next.far_x        = far_x_next;
        out_word_next.far_y        = far_y_next;
        out_word_next.dash_pattern = pattern_next;
        out_word_next.dragging     = drag_active_next;
        out_word_next.was_inside   = in_window;
    end

    // control and tracker state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
            anchor_x_reg      <= '0;
            anchor_y_reg      <= '0;
            far_x_reg         <= '0;
            far_y_reg         <= '0;
            box_reg           <= '0;
            pattern_reg       <= PATTERN_RESET;
            drag_active_reg   <= 1'b0;
            bounding_mode_reg <= 1'b0;
        end
        else
        begin
            if (!in_stall)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg     <= 1'b1;
                anchor_x_reg      <= anchor_x_next;
                anchor_y_reg      <= anchor_y_next;
                far_x_reg         <= far_x_next;
                far_y_reg         <= far_y_next;
                box_reg           <= box_next;
                pattern_reg       <= pattern_next;
                drag_active_reg   <= drag_active_next;
                bounding_mode_reg <= bounding_mode_next;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            in_word_reg <= in_word;
        end
        if (advance)
        begin
            out_word_reg <= out_word_next;
        end
    end

    // drag and box rebuild are always started and stopped together
    assert property (@(posedge clk) disable iff (!rst_n)
        drag_active_reg == bounding_mode_reg)
        else $error("drag and bounding flags disagree");

    // rotations keep the dash pattern's population
    assert property (@(posedge clk) disable iff (!rst_n)
        $countones(pattern_reg) == 8)
        else $error("dash pattern lost or gained bits");

    // a waiting result reports the drag state it left behind
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_word_reg.dragging == drag_active_reg))
        else $error("result drag flag out of step with state");

    // the input side stalls only while an event is held
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> in_valid_reg)
        else $error("stall without a held event");

    // a processed event always lands in the result register
    assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("processed event produced no result");

endmodule

>>> tb/sv/tb.sv
// self-checking testbench for the selection rectangle tracker
`timescale 1ns / 1ps

module tb;
    import srt_pkg::*;

    // event codes the package leaves unnamed: other button and the spare codes
    localparam logic [2:0] OP_OTHER  = 3'd4;
    localparam logic [2:0] OP_RSVD_5 = 3'd5;
    localparam logic [2:0] OP_RSVD_6 = 3'd6;
    localparam logic [2:0] OP_RSVD_7 = 3'd7;

    localparam int CLIP_MAX      = 32767;
    localparam int PHASE_EVENTS  = 219;   // press, release, menu and move words per phase
    localparam int PHASES        = 8;
    localparam int SETTLE_CYCLES = 4;     // two-stage pipe plus margin
    localparam int DRAIN_LIMIT   = 20000;

    // receiver behavior, switched after each run of random length
    typedef enum logic [1:0] {FLOW_FREE, FLOW_LIGHT, FLOW_HEAVY, FLOW_HOLD} flow_t;

    typedef struct packed {
        logic [CLIP_W-1:0] left;
        logic [CLIP_W-1:0] top;
        logic [CLIP_W-1:0] right;
        logic [CLIP_W-1:0] bottom;
    } window_t;

    // one directed step: the event, and a hand-written result where it is obvious
    typedef struct packed {
        srt_in_t  ev;
        logic     known;
        srt_out_t want;
    } dir_row_t;

    // results that follow directly from the reset state
    localparam srt_out_t REST_INSIDE = '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0,
                                         16'd0, PATTERN_RESET, 1'b0, 1'b1};
    localparam srt_out_t REST_OUTSIDE = '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0,
                                          16'd0, PATTERN_RESET, 1'b0, 1'b0};
    // first press at (100, 50) with the reset window: one-pixel box, drag on
    localparam srt_out_t FIRST_ANCHOR = '{16'd100, 16'd50, 16'd1, 16'd1, 16'd100, 16'd50,
                                          16'd100, 16'd50, PATTERN_RESET, 1'b1, 1'b1};
    localparam srt_out_t NO_WORD = '0;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              in_valid  = 1'b0;
    logic              in_stall;
    srt_in_t           in_word   = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    srt_out_t          out_word;
    logic              cfg_write = 1'b0;
    logic [1:0]        cfg_index = CFG_CLIP_LEFT;
    logic [CLIP_W-1:0] cfg_data  = '0;

    selection_rectangle_tracker i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // ------------------------------------------------------------------
    // tracker predictor: clip window, corners, box, dash pattern, drag flags
    // ------------------------------------------------------------------
    logic [CLIP_W-1:0] win_left   = CLIP_LEFT_RESET;
    logic [CLIP_W-1:0] win_top    = CLIP_TOP_RESET;
    logic [CLIP_W-1:0] win_right  = CLIP_RIGHT_RESET;
    logic [CLIP_W-1:0] win_bottom = CLIP_BOTTOM_RESET;
    logic [15:0]       corner_ax  = '0;
    logic [15:0]       corner_ay  = '0;
    logic [15:0]       corner_fx  = '0;
    logic [15:0]       corner_fy  = '0;
    srt_box_t          sel_box    = '0;
    logic [15:0]       dash_q     = PATTERN_RESET;
    logic              drag_on    = 1'b0;
    logic              box_live   = 1'b0;

    srt_out_t pending_words [$];
    int       mismatches    = 0;
    int       active_events = 0;
    int       burst_left    = 0;

    // signed clamp, low bound checked first: in an inverted window values below lo pin to lo, all others to hi
    function automatic int clamp_to(input int p, input int lo, input int hi);
        if (p < lo)
            return lo;
        if (p > hi)
            return hi;
        return p;
    endfunction

    // normalized box spanned by anchor and far corner, sizes wrap at 16 bits
    function automatic srt_box_t span_box(input logic [15:0] ax, input logic [15:0] ay,
                                          input logic [15:0] fx, input logic [15:0] fy);
        srt_box_t    b;
        logic [15:0] x0;
        logic [15:0] x1;
        logic [15:0] y0;
        logic [15:0] y1;
        if (fx < ax) begin
            x0 = fx;
            x1 = ax;
        end else begin
            x0 = ax;
            x1 = fx;
        end
        if (fy < ay) begin
            y0 = fy;
            y1 = ay;
        end else begin
            y0 = ay;
            y1 = fy;
        end
        b.left   = x0;
        b.top    = y0;
        b.width  = x1 - x0 + 16'd1;
        b.height = y1 - y0 + 16'd1;
        return b;
    endfunction

    // advance the predicted tracker by one event and return the result word
    function automatic srt_out_t track_event(input srt_in_t ev);
        int          px;
        int          py;
        int          cx;
        int          cy;
        logic [15:0] mx;
        logic [15:0] my;
        logic        in_window;
        logic        turn_right;
        srt_out_t    r;
        px = $signed(ev.pointer_x);
        py = $signed(ev.pointer_y);
        cx = clamp_to(px, int'(win_left), int'(win_right));
        cy = clamp_to(py, int'(win_top), int'(win_bottom));
        in_window = (cx == px) && (cy == py);
        mx = cx[15:0];
        my = cy[15:0];
        case (ev.opcode)
            OP_SELECT_PRESS: begin
                // any drag ends; a press inside the window starts a fresh one
                drag_on  = 1'b0;
                box_live = 1'b0;
                if (in_window) begin
                    corner_ax = mx;
                    corner_fx = mx;
                    corner_ay = my;
                    corner_fy = my;
                    sel_box   = span_box(corner_ax, corner_ay, corner_fx, corner_fy);
                    drag_on   = 1'b1;
                    box_live  = 1'b1;
                end
            end
            OP_MENU_PRESS: begin
                drag_on        = 1'b0;
                box_live       = 1'b0;
                sel_box.width  = '0;
                sel_box.height = '0;
            end
            OP_SELECT_RELEASE: begin
                if (box_live)
                    sel_box = span_box(corner_ax, corner_ay, corner_fx, corner_fy);
                drag_on  = 1'b0;
                box_live = 1'b0;
            end
            OP_MOVE: begin
                if (drag_on) begin
                    // marching direction from the corners before this move
                    turn_right = (corner_ax < corner_fx) || (corner_ay > corner_fy);
                    dash_q = turn_right ? {dash_q[0], dash_q[15:1]} : {dash_q[14:0], dash_q[15]};
                    if (ev.shift_x != '0 && ev.shift_y != '0) begin
                        corner_ax = corner_ax + ev.shift_x;
                        corner_ay = corner_ay + ev.shift_y;
                    end else begin
                        corner_fx = mx;
                        corner_fy = my;
                    end
                    if (box_live)
                        sel_box = span_box(corner_ax, corner_ay, corner_fx, corner_fy);
                end
            end
            default: ;
        endcase
        r.box_left     = sel_box.left;
        r.box_top      = sel_box.top;
        r.box_width    = sel_box.width;
        r.box_height   = sel_box.height;
        r.anchor_x     = corner_ax;
        r.anchor_y     = corner_ay;
        r.far_x        = corner_fx;
        r.far_y        = corner_fy;
        r.dash_pattern = dash_q;
        r.dragging     = drag_on;
        r.was_inside   = in_window;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // clock, timeout
    // ------------------------------------------------------------------
    initial begin
        forever #5 clk = ~clk;
    end

    // far beyond the slowest legal run (roughly 1800 words, long receiver holds)
    initial begin
        #10000000;
        $display("FAIL selection_rectangle_tracker");
        $finish;
    end

    // ------------------------------------------------------------------
    // receiver: stall pattern changes between free flow, light, heavy and hold
    // ------------------------------------------------------------------
    flow_t flow_mode = FLOW_FREE;
    int    flow_run  = 0;

    always @(posedge clk) begin
        if (flow_run == 0) begin
            flow_mode = flow_t'($urandom_range(3));
            flow_run  = $urandom_range(5, 60);
        end
        flow_run = flow_run - 1;
        case (flow_mode)
            FLOW_FREE:  out_stall <= 1'b0;
            FLOW_LIGHT: out_stall <= ($urandom_range(2) == 0);
            FLOW_HEAVY: out_stall <= ($urandom_range(3) != 0);
            default:    out_stall <= 1'b1;
        endcase
    end

    // ------------------------------------------------------------------
    // result checker: each accepted word against the oldest prediction
    // ------------------------------------------------------------------
    task automatic compare_field(input string name, input logic [15:0] exp_v,
                                 input logic [15:0] act_v);
        if (exp_v !== act_v) begin
            mismatches++;
            $error("%s: expected %0h, got %0h", name, exp_v, act_v);
        end
    endtask

    always @(posedge clk) begin : check_results
        srt_out_t want;
        if (rst_n && out_valid && !out_stall) begin
            if (pending_words.size() == 0) begin
                mismatches++;
                $error("result word with nothing expected");
            end else begin
                want = pending_words.pop_front();
                compare_field("box_left", want.box_left, out_word.box_left);
                compare_field("box_top", want.box_top, out_word.box_top);
                compare_field("box_width", want.box_width, out_word.box_width);
                compare_field("box_height", want.box_height, out_word.box_height);
                compare_field("anchor_x", want.anchor_x, out_word.anchor_x);
                compare_field("anchor_y", want.anchor_y, out_word.anchor_y);
                compare_field("far_x", want.far_x, out_word.far_x);
                compare_field("far_y", want.far_y, out_word.far_y);
                compare_field("dash_pattern", want.dash_pattern, out_word.dash_pattern);
                compare_field("dragging", {15'd0, want.dragging}, {15'd0, out_word.dragging});
                compare_field("was_inside", {15'd0, want.was_inside},
                              {15'd0, out_word.was_inside});
            end
        end
    end

    // ------------------------------------------------------------------
    // sender
    // ------------------------------------------------------------------

    // hold the word until the block takes it, then predict its result
    task automatic send_word(input srt_in_t ev, input logic known, input srt_out_t want);
        srt_out_t predicted;
        in_valid <= 1'b1;
        in_word  <= ev;
        do
            @(posedge clk);
        while (in_stall);
        predicted = track_event(ev);
        pending_words.push_back(known ? want : predicted);
        if (ev.opcode <= OP_MOVE)
            active_events++;
    endtask

    // bursts of random length; between bursts a random gap, often none at all
    task automatic paced_send(input srt_in_t ev, input logic known, input srt_out_t want);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        send_word(ev, known, want);
    endtask

    // sender stops until every predicted word is out and the pipe is quiet
    task automatic drain_pipeline;
        int waited;
        waited = 0;
        in_valid <= 1'b0;
        while (pending_words.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [CLIP_W-1:0] value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        case (idx)
            CFG_CLIP_LEFT:  win_left   = value;
            CFG_CLIP_TOP:   win_top    = value;
            CFG_CLIP_RIGHT: win_right  = value;
            default:        win_bottom = value;
        endcase
    endtask

    task automatic write_window(input window_t w);
        write_reg(CFG_CLIP_LEFT, w.left);
        write_reg(CFG_CLIP_TOP, w.top);
        write_reg(CFG_CLIP_RIGHT, w.right);
        write_reg(CFG_CLIP_BOTTOM, w.bottom);
        cfg_write <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // random event content
    // ------------------------------------------------------------------

    // coordinate inside [lo..hi]; an inverted window has no inside, so lo is used
    function automatic logic [15:0] inner_coord(input logic [CLIP_W-1:0] lo,
                                                input logic [CLIP_W-1:0] hi);
        int v;
        v = int'(lo);
        if (lo <= hi)
            v = v + int'($urandom_range(int'(hi) - int'(lo)));
        return v[15:0];
    endfunction

    // mostly inside, sometimes just outside either edge, sometimes anywhere
    function automatic logic [15:0] near_coord(input logic [CLIP_W-1:0] lo,
                                               input logic [CLIP_W-1:0] hi);
        int v;
        case ($urandom_range(9))
            0:       v = int'($urandom_range(16'hffff));
            1:       v = int'(lo) - int'($urandom_range(1, 40));
            2:       v = int'(hi) + int'($urandom_range(1, 40));
            default: v = int'(inner_coord(lo, hi));
        endcase
        return v[15:0];
    endfunction

    function automatic logic [15:0] small_shift;
        int v;
        v = $urandom_range(1, 20);
        if ($urandom_range(1) == 1)
            v = -v;
        return v[15:0];
    endfunction

    // anchor shifts: both zero, one zero, small pair or full-range pair
    task automatic pick_shifts(inout srt_in_t ev);
        case ($urandom_range(7))
            1: begin
                ev.shift_x = small_shift();
                ev.shift_y = '0;
            end
            2: begin
                ev.shift_x = '0;
                ev.shift_y = 16'($urandom_range(16'hffff));
            end
            3, 4: begin
                ev.shift_x = small_shift();
                ev.shift_y = small_shift();
            end
            5: begin
                ev.shift_x = 16'($urandom_range(16'hffff));
                ev.shift_y = 16'($urandom_range(16'hffff));
            end
            default: begin
                ev.shift_x = '0;
                ev.shift_y = '0;
            end
        endcase
    endtask

    // press inside, a run of moves, then mostly a release or a menu press
    task automatic drag_gesture;
        srt_in_t ev;
        int      moves;
        ev.opcode    = OP_SELECT_PRESS;
        ev.pointer_x = inner_coord(win_left, win_right);
        ev.pointer_y = inner_coord(win_top, win_bottom);
        ev.shift_x   = 16'($urandom_range(16'hffff));
        ev.shift_y   = 16'($urandom_range(16'hffff));
        paced_send(ev, 1'b0, NO_WORD);
        moves = $urandom_range(1, 12);
        repeat (moves) begin
            ev.opcode    = OP_MOVE;
            ev.pointer_x = near_coord(win_left, win_right);
            ev.pointer_y = near_coord(win_top, win_bottom);
            pick_shifts(ev);
            paced_send(ev, 1'b0, NO_WORD);
        end
        ev.pointer_x = near_coord(win_left, win_right);
        ev.pointer_y = near_coord(win_top, win_bottom);
        case ($urandom_range(9))
            0, 1, 2, 3, 4, 5: begin
                ev.opcode = OP_SELECT_RELEASE;
                paced_send(ev, 1'b0, NO_WORD);
            end
            6, 7: begin
                ev.opcode = OP_MENU_PRESS;
                paced_send(ev, 1'b0, NO_WORD);
            end
            default: ;  // left open, the next press cuts it off
        endcase
    endtask

    // any code, any field value
    task automatic noise_event;
        srt_in_t ev;
        ev.opcode    = 3'($urandom_range(7));
        ev.pointer_x = 16'($urandom_range(16'hffff));
        ev.pointer_y = 16'($urandom_range(16'hffff));
        ev.shift_x   = 16'($urandom_range(16'hffff));
        ev.shift_y   = 16'($urandom_range(16'hffff));
        paced_send(ev, 1'b0, NO_WORD);
    endtask

    // ------------------------------------------------------------------
    // directed steps, reset window 0..639 x 0..199
    // ------------------------------------------------------------------
    dir_row_t directed_steps [24] = '{
        // idle block: move without drag, other button, press outside, release, menu, first press
        '{'{OP_MOVE, 16'sd10, 16'sd10, 16'sd0, 16'sd0}, 1'b1, REST_INSIDE},
        '{'{OP_OTHER, -16'sd1, -16'sd1, 16'sd0, 16'sd0}, 1'b1, REST_OUTSIDE},
        '{'{OP_SELECT_PRESS, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000}, 1'b1, REST_OUTSIDE},
        '{'{OP_SELECT_RELEASE, 16'sd639, 16'sd199, 16'sd0, 16'sd0}, 1'b1, REST_INSIDE},
        '{'{OP_MENU_PRESS, 16'sd640, 16'sd0, 16'sd0, 16'sd0}, 1'b1, REST_OUTSIDE},
        '{'{OP_SELECT_PRESS, 16'sd100, 16'sd50, 16'sd0, 16'sd0}, 1'b1, FIRST_ANCHOR},
        // drag: far corner moves, clamped pointer, anchor shifts with wrap
        '{'{OP_MOVE, 16'sd300, 16'sd20, 16'sd0, 16'sd0}, 1'b0, NO_WORD},
        '{'{OP_MOVE, 16'sh7fff, 16'sh8000, 16'sd0, 16'sd0}, 1'b0, NO_WORD},
        '{'{OP_MOVE, 16'sd0, 16'sd199, 16'sd5, -16'sd3}, 1'b0, NO_WORD},
        '{'{OP_MOVE, 16'sd1, 16'sd1, 16'sd7, 16'sd0}, 1'b0, NO_WORD},
        '{'{OP_MOVE, 16'sd2, 16'sd2, 16'sh7fff, 16'sh8000}, 1'b0, NO_WORD},
        '{'{OP_MOVE, 16'sd3, 16'sd3, -16'sd1, -16'sd1}, 1'b0, NO_WORD},
        // spare codes change nothing; a release and an idle move follow
        '{'{OP_RSVD_5, -16'sd1, -16'sd1, -16'sd1, -16'sd1}, 1'b0, NO_WORD},
        '{'{OP_RSVD_6, 16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b0, NO_WORD},
        '{'{OP_RSVD_7, 16'sd200, 16'sd100, 16'sd0, 16'sd0}, 1'b0, NO_WORD},
        '{'{OP_SELECT_RELEASE, 16'sd10, 16'sd10, 16'sd0, 16'sd0}, 1'b0, NO_WORD},
        '{'{OP_MOVE, 16'sd50, 16'sd50, 16'sd0, 16'sd0}, 1'b0, NO_WORD},
        // press on the corner of the window, drag to the opposite corner
        '{'{OP_SELECT_PRESS, 16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b0, NO_WORD},
        '{'{OP_MOVE, 16'sd639, 16'sd199, 16'sd0, 16'sd0}, 1'b0, NO_WORD},
        // press just outside during a drag ends it with corners kept
        '{'{OP_SELECT_PRESS, 16'sd640, 16'sd10, 16'sd0, 16'sd0}, 1'b0, NO_WORD},
        '{'{OP_MOVE, 16'sd5, 16'sd5, 16'sd0, 16'sd0}, 1'b0, NO_WORD},
        // menu press zeroes the size, a later release leaves the box alone
        '{'{OP_SELECT_PRESS, 16'sd20, 16'sd30, 16'sd0, 16'sd0}, 1'b0, NO_WORD},
        '{'{OP_MENU_PRESS, 16'sd20, 16'sd30, 16'sd0, 16'sd0}, 1'b0, NO_WORD},
        '{'{OP_SELECT_RELEASE, 16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b0, NO_WORD}
    };

    // fixed windows: full range, all zero, all at the top, inverted, tiny
    window_t fixed_windows [5] = '{
        '{15'd0, 15'd0, 15'd32767, 15'd32767},
        '{15'd0, 15'd0, 15'd0, 15'd0},
        '{15'd32767, 15'd32767, 15'd32767, 15'd32767},
        '{15'd500, 15'd300, 15'd100, 15'd50},
        '{15'd10, 15'd20, 15'd30, 15'd40}
    };

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin : main_sequence
        window_t w;
        int      phase_start;
        int      lo;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_steps[k])
            paced_send(directed_steps[k].ev, directed_steps[k].known, directed_steps[k].want);

        for (int ph = 0; ph < PHASES; ph++) begin
            // phase zero keeps the reset window; later phases rewrite left, top, right and bottom
            if (ph > 0) begin
                drain_pipeline();
                if (ph <= 5) begin
                    w = fixed_windows[ph - 1];
                end else if (ph == 6) begin
                    lo       = $urandom_range(CLIP_MAX - 1000);
                    w.left   = 15'(lo);
                    w.right  = 15'(lo + int'($urandom_range(800)));
                    lo       = $urandom_range(CLIP_MAX - 1000);
                    w.top    = 15'(lo);
                    w.bottom = 15'(lo + int'($urandom_range(800)));
                end else begin
                    w.left   = 15'($urandom_range(CLIP_MAX));
                    w.top    = 15'($urandom_range(CLIP_MAX));
                    w.right  = 15'($urandom_range(CLIP_MAX));
                    w.bottom = 15'($urandom_range(CLIP_MAX));
                end
                write_window(w);
            end
            phase_start = active_events;
            while (active_events - phase_start < PHASE_EVENTS) begin
                if ($urandom_range(99) < 82)
                    drag_gesture();
                else
                    noise_event();
            end
        end

        drain_pipeline();
        if (pending_words.size() != 0) begin
            mismatches++;
            $error("%0d result words never arrived", pending_words.size());
        end
        if (mismatches == 0)
            $display("PASS selection_rectangle_tracker");
        else
            $display("FAIL selection_rectangle_tracker");
        $finish;
    end

endmodule

>>> filelist.f
rtl/srt_pkg.sv
rtl/selection_rectangle_tracker.sv
tb/sv/tb.sv
